/* design/mlnkt_pkg.sv */
// shared types and constants of the monophonic last-note key tracker
package mlnkt_pkg;

	localparam int KEY_COUNT = 128;
	localparam int KEY_AW    = $clog2(KEY_COUNT);
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;
	localparam int COUNT_W   = 8;

	// status byte high nibbles that act
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;

	// reported event codes
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} mlnkt_ev_t;

	// write port of the held-key map
	typedef struct packed {
		logic              en;
		logic [KEY_AW-1:0] addr;
		logic              held;
	} mlnkt_wr_t;

endpackage

/* design/mono_last_note_key_tracker.sv */
// top level of the monophonic last-note key tracker
//
// One MIDI message per transfer on the s_axis channel; one result per message
// on the m_axis channel, in arrival order. Note-on (status nibble 9) and
// note-off (nibble 8) act, any channel; note-on with velocity zero releases.
// A note-on of a note other than the current one takes over and reports a
// press; releasing the current note reports a release.
//
// Throughput: one message per cycle while the receiver does not stall. The
// held-key map is a 128 x 1 memory with one read port and one write port and
// a registered read; the read is issued at acceptance and the write-back
// happens when the message leaves stage 1, with the write of the message ahead
// forwarded to the message behind when both touch the same key.
//
// Reset: all keys released, count zero, no current note; the map is cleared
// at once by per-entry valid bits, so messages are taken right after reset.
// Stall: the output register holds a result until m_axis_tready; the stage
// behind it holds one more message, and only then does s_axis_tready drop.
module mono_last_note_key_tracker
	import mlnkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// status_byte[7:0], note[14:8], velocity[21:15], zero[23:22]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// event_kind[1:0], event_note[8:2], event_velocity[15:9], keys_down[23:16],
	// playing_valid[24], playing_note[31:25], playing_velocity[38:32], zero[39]
	output logic [39:0] m_axis_tdata
);

	// input transfer fields
	logic [7:0]        in_status;
	logic [NOTE_W-1:0] in_note;
	logic [VEL_W-1:0]  in_vel;
	logic              in_fire;

	// stage 1 registers
	logic              valid_s1;
	logic [3:0]        kind_s1;
	logic [NOTE_W-1:0] note_s1;
	logic [VEL_W-1:0]  vel_s1;

	// tracker state
	logic [COUNT_W-1:0] total_q;
	logic               cur_valid_q;
	logic [NOTE_W-1:0]  cur_note_q;
	logic [VEL_W-1:0]   cur_vel_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic [NOTE_W-1:0]  out_note_q;
	logic [VEL_W-1:0]   out_vel_q;
	logic [COUNT_W-1:0] out_total_q;
	logic               out_cur_valid_q;
	logic [NOTE_W-1:0]  out_cur_note_q;
	logic [VEL_W-1:0]   out_cur_vel_q;

	// stage 1 logic
	logic               fire_s1;
	logic               held_s1;
	logic               is_on;
	logic               is_off;
	mlnkt_wr_t          map_wr;
	mlnkt_ev_t          ev_n;
	logic [NOTE_W-1:0]  ev_note_n;
	logic [VEL_W-1:0]   ev_vel_n;
	logic [COUNT_W-1:0] total_n;
	logic               cur_valid_n;
	logic [NOTE_W-1:0]  cur_note_n;
	logic [VEL_W-1:0]   cur_vel_n;

	assign in_status = s_axis_tdata[7:0];
	assign in_note   = s_axis_tdata[14:8];
	assign in_vel    = s_axis_tdata[21:15];

	// handshake: stage 1 drains into the output register when it is free
	assign fire_s1       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	mlnkt_key_map u_key_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (in_note),
		.wr      (map_wr),
		.rd_held (held_s1)
	);

	// stage 1 pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= in_status[7:4];
			note_s1 <= in_note;
			vel_s1  <= in_vel;
		end
	end

	// decode and next state
	always_comb begin
		is_on       = (kind_s1 == NIB_NOTE_ON) && (vel_s1 != '0);
		is_off      = !is_on && ((kind_s1 == NIB_NOTE_ON) || (kind_s1 == NIB_NOTE_OFF));
		ev_n        = EV_NONE;
		ev_note_n   = '0;
		ev_vel_n    = '0;
		total_n     = total_q;
		cur_valid_n = cur_valid_q;
		cur_note_n  = cur_note_q;
		cur_vel_n   = cur_vel_q;
		if (is_on) begin
			if (!held_s1 && (total_q < COUNT_W'(KEY_COUNT))) begin
				total_n = total_q + 1'b1;
			end
			if (!cur_valid_q || (cur_note_q != note_s1)) begin
				cur_valid_n = 1'b1;
				cur_note_n  = note_s1;
				cur_vel_n   = vel_s1;
				ev_n        = EV_PRESS;
				ev_note_n   = note_s1;
				ev_vel_n    = vel_s1;
			end
		end else if (is_off) begin
			if (held_s1 && (total_q != '0)) begin
				total_n = total_q - 1'b1;
			end
			if (cur_valid_q && (cur_note_q == note_s1)) begin
				cur_valid_n = 1'b0;
				cur_note_n  = '0;
				cur_vel_n   = '0;
				ev_n        = EV_RELEASE;
				ev_note_n   = note_s1;
				ev_vel_n    = vel_s1;
			end
		end
		map_wr.en   = fire_s1 && (is_on || is_off);
		map_wr.addr = note_s1;
		map_wr.held = is_on;
	end

	// tracker state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_note_q  <= '0;
			cur_vel_q   <= '0;
		end else if (fire_s1) begin
			total_q     <= total_n;
			cur_valid_q <= cur_valid_n;
			cur_note_q  <= cur_note_n;
			cur_vel_q   <= cur_vel_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_kind_q      <= ev_n;
			out_note_q      <= ev_note_n;
			out_vel_q       <= ev_vel_n;
			out_total_q     <= total_n;
			out_cur_valid_q <= cur_valid_n;
			out_cur_note_q  <= cur_note_n;
			out_cur_vel_q   <= cur_vel_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_cur_vel_q, out_cur_note_q, out_cur_valid_q,
		out_total_q, out_vel_q, out_note_q, out_kind_q};

	// checks on the tracker state
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= COUNT_W'(KEY_COUNT))
		else $error("held key count above key count");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!cur_valid_q |-> (cur_note_q == '0) && (cur_vel_q == '0))
		else $error("current note fields not cleared");

	a_press_takes_over: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (ev_n == EV_PRESS) |=> cur_valid_q && (cur_note_q == $past(note_s1)))
		else $error("press did not take over the current note");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (ev_n == EV_RELEASE) |=> !cur_valid_q)
		else $error("release left a current note");

	a_output_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

/* design/mlnkt_key_map.sv */
// held-key map: synchronous memory with reset valid bits and write forwarding
module mlnkt_key_map
	import mlnkt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [KEY_AW-1:0] rd_addr,
	input  mlnkt_wr_t         wr,
	output logic              rd_held
);

	logic                mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] valid_q;
	logic                rd_mem_q;
	logic                rd_vld_q;
	logic                fwd_hit_q;
	logic                fwd_val_q;

	// memory array, no reset
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.held;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	// entry valid bits, cleared at reset so every key reads as released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
			fwd_val_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= valid_q[rd_addr];
				// a write landing at the same edge as the read is forwarded
				fwd_hit_q <= wr.en && (wr.addr == rd_addr);
				fwd_val_q <= wr.held;
			end
		end
	end

	assign rd_held = fwd_hit_q ? fwd_val_q : (rd_vld_q & rd_mem_q);

endmodule

/* sim/mono_last_note_key_tracker_tb.sv */
// self-checking testbench of the monophonic last-note key tracker
module mono_last_note_key_tracker_tb;
	import mlnkt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DIR_ROWS     = 22;

	// one result item as it leaves on m_axis
	typedef struct packed {
		mlnkt_ev_t          event_kind;
		logic [NOTE_W-1:0]  event_note;
		logic [VEL_W-1:0]   event_velocity;
		logic [COUNT_W-1:0] keys_down;
		logic               playing_valid;
		logic [NOTE_W-1:0]  playing_note;
		logic [VEL_W-1:0]   playing_velocity;
	} key_result_t;

	// one directed message, with its result typed in where it is obvious
	typedef struct packed {
		logic [7:0]        status;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic              typed;
		key_result_t       res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	// predicted tracker state
	logic [KEY_COUNT-1:0] held_keys;
	logic [COUNT_W-1:0]   held_count;
	logic                 cur_on;
	logic [NOTE_W-1:0]    cur_note;
	logic [VEL_W-1:0]     cur_vel;

	key_result_t note_events_q[$];
	int          mismatches = 0;
	int          cycles = 0;
	logic        no_idle = 1'b0;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{8'h90, 7'd0,   7'd1,   1'b1, '{EV_PRESS,   7'd0,   7'd1,   8'd1, 1'b1, 7'd0,   7'd1}},
		'{8'h9F, 7'd127, 7'd127, 1'b1, '{EV_PRESS,   7'd127, 7'd127, 8'd2, 1'b1, 7'd127, 7'd127}},
		'{8'h9F, 7'd127, 7'd5,   1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd2, 1'b1, 7'd127, 7'd127}},
		'{8'h80, 7'd127, 7'd64,  1'b1, '{EV_RELEASE, 7'd127, 7'd64,  8'd1, 1'b0, 7'd0,   7'd0}},
		'{8'h80, 7'd0,   7'd127, 1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'h8F, 7'd5,   7'd3,   1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'h90, 7'd60,  7'd0,   1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'h00, 7'd60,  7'd100, 1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'hFF, 7'd127, 7'd127, 1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'hA0, 7'd1,   7'd1,   1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'h7F, 7'd2,   7'd2,   1'b1, '{EV_NONE,    7'd0,   7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'h95, 7'd60,  7'd100, 1'b1, '{EV_PRESS,   7'd60,  7'd100, 8'd1, 1'b1, 7'd60,  7'd100}},
		'{8'h90, 7'd60,  7'd0,   1'b1, '{EV_RELEASE, 7'd60,  7'd0,   8'd0, 1'b0, 7'd0,   7'd0}},
		'{8'h91, 7'd61,  7'd10,  1'b0, '0},
		'{8'h92, 7'd62,  7'd20,  1'b0, '0},
		// held key that is not current takes over, count stays
		'{8'h93, 7'd61,  7'd30,  1'b0, '0},
		'{8'h93, 7'd61,  7'd40,  1'b0, '0},
		// release of a held key that is not current
		'{8'h84, 7'd62,  7'd1,   1'b0, '0},
		'{8'h94, 7'd62,  7'd0,   1'b0, '0},
		'{8'h85, 7'd61,  7'd127, 1'b0, '0},
		'{8'h9F, 7'd127, 7'd1,   1'b0, '0},
		'{8'h8F, 7'd127, 7'd0,   1'b0, '0}
	};

	mono_last_note_key_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// apply one message to the predicted state and return its result
	task automatic track_message(input logic [7:0] status, input logic [NOTE_W-1:0] note,
			input logic [VEL_W-1:0] vel, output key_result_t r);
		logic [3:0] nib;
		nib = status[7:4];
		r = '0;
		if (nib == NIB_NOTE_ON && vel != '0) begin
			if (!held_keys[note]) begin
				held_keys[note] = 1'b1;
				if (held_count < KEY_COUNT) held_count = held_count + 1'b1;
			end
			if (!cur_on || cur_note != note) begin
				cur_on = 1'b1;
				cur_note = note;
				cur_vel = vel;
				r.event_kind = EV_PRESS;
				r.event_note = note;
				r.event_velocity = vel;
			end
		end else if (nib == NIB_NOTE_ON || nib == NIB_NOTE_OFF) begin
			if (held_keys[note]) begin
				held_keys[note] = 1'b0;
				if (held_count > 0) held_count = held_count - 1'b1;
			end
			if (cur_on && cur_note == note) begin
				cur_on = 1'b0;
				cur_note = '0;
				cur_vel = '0;
				r.event_kind = EV_RELEASE;
				r.event_note = note;
				r.event_velocity = vel;
			end
		end
		r.keys_down = held_count;
		r.playing_valid = cur_on;
		r.playing_note = cur_note;
		r.playing_velocity = cur_vel;
	endtask

	// drive one message, with random gaps, until it is transferred
	task automatic send_msg(input logic [7:0] status, input logic [NOTE_W-1:0] note,
			input logic [VEL_W-1:0] vel, input logic typed = 1'b0,
			input key_result_t typed_res = '0);
		key_result_t r;
		while (!no_idle && $urandom_range(0, 99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, vel, note, status};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_message(status, note, vel, r);
		note_events_q.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	// hold the sender off until every result is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (note_events_q.size() != 0) @(negedge clk);
	endtask

	// random traffic biased toward the current note and a small cluster of keys
	task automatic random_burst(input int count);
		int               pick;
		logic [7:0]       status;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25 && cur_on) note = cur_note;
			else if (pick < 60) note = NOTE_W'($urandom_range(60, 67));
			else note = NOTE_W'($urandom_range(0, 127));
			vel = ($urandom_range(0, 9) == 0) ? '0 : VEL_W'($urandom_range(1, 127));
			pick = $urandom_range(0, 99);
			if (pick < 50) status = {NIB_NOTE_ON, 4'($urandom_range(0, 15))};
			else if (pick < 80) status = {NIB_NOTE_OFF, 4'($urandom_range(0, 15))};
			else status = 8'($urandom_range(0, 255));
			send_msg(status, note, vel);
		end
	endtask

	task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// receiver stalls at random except in the back-to-back stretch
	always @(negedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 29);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		key_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (note_events_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				want = note_events_q.pop_front();
				cmp_field("event_kind", want.event_kind, m_axis_tdata[1:0]);
				cmp_field("event_note", want.event_note, m_axis_tdata[8:2]);
				cmp_field("event_velocity", want.event_velocity, m_axis_tdata[15:9]);
				cmp_field("keys_down", want.keys_down, m_axis_tdata[23:16]);
				cmp_field("playing_valid", want.playing_valid, m_axis_tdata[24]);
				cmp_field("playing_note", want.playing_note, m_axis_tdata[31:25]);
				cmp_field("playing_velocity", want.playing_velocity, m_axis_tdata[38:32]);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout at %0t with %0d results outstanding", $time,
				note_events_q.size());
			$display("[mono_last_note_key_tracker] ERROR");
			$finish;
		end
	end

	initial begin
		held_keys = '0;
		held_count = '0;
		cur_on = 1'b0;
		cur_note = '0;
		cur_vel = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++)
			send_msg(dir_rows[i].status, dir_rows[i].note, dir_rows[i].vel,
				dir_rows[i].typed, dir_rows[i].res);
		wait_drained();

		random_burst(400);

		// press every key upward, then release all from the top
		for (int k = 0; k < KEY_COUNT; k++)
			send_msg({NIB_NOTE_ON, 4'($urandom_range(0, 15))}, NOTE_W'(k),
				VEL_W'($urandom_range(1, 127)));
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if ($urandom_range(0, 1) == 1)
				send_msg({NIB_NOTE_ON, 4'($urandom_range(0, 15))}, NOTE_W'(k), '0);
			else
				send_msg({NIB_NOTE_OFF, 4'($urandom_range(0, 15))}, NOTE_W'(k),
					VEL_W'($urandom_range(0, 127)));
		end
		wait_drained();

		// back-to-back stretch on both sides
		no_idle = 1'b1;
		random_burst(300);
		no_idle = 1'b0;
		random_burst(850);

		s_axis_tvalid <= 1'b0;
		while (note_events_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[mono_last_note_key_tracker] OK");
		else
			$display("[mono_last_note_key_tracker] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
design/mlnkt_pkg.sv
design/mlnkt_key_map.sv
design/mono_last_note_key_tracker.sv
sim/mono_last_note_key_tracker_tb.sv
